// ===== sv/iou_ta_pkg.sv =====
// Package for the IoU track association block: constants, table entry,
// controller states and the command/status structs. No dependencies.
package iou_ta_pkg;

  localparam int TRACK_SLOTS_DEF = 16;
  localparam int COORD_BITS      = 12;
  localparam int SIZE_BITS       = 13;
  localparam int TIME_BITS       = 32;
  localparam int AREA_BITS       = 2 * COORD_BITS;
  localparam int SLOT_OUT_BITS   = 4;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_IDX_BITS    = 2;

  localparam logic [TIME_BITS-1:0] CAPTURE_DELAY_RST = 32'd1000;
  localparam logic [SIZE_BITS-1:0] FRAME_WIDTH_RST   = 13'd1280;
  localparam logic [SIZE_BITS-1:0] FRAME_HEIGHT_RST  = 13'd720;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CAPTURE_DELAY = 2'd0,
    CFG_FRAME_WIDTH   = 2'd1,
    CFG_FRAME_HEIGHT  = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DIFF, ST_MUL, ST_CMP, ST_WOLD, ST_WNEW, ST_FREE, ST_FIN
  } ctl_state_e;

  typedef enum logic [1:0] {
    RES_EMPTY, RES_MATCH, RES_NEW, RES_DROP
  } res_kind_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
    logic [AREA_BITS-1:0]  area;
    logic [TIME_BITS-1:0]  start;
    logic                  captured;
  } entry_t;

  typedef struct packed {
    logic      in_ready;
    logic      idx_clr;
    logic      idx_inc;
    logic      rd;
    logic      wr_en;
    logic      wr_new;
    logic      wr_fresh;
    logic      set_valid;
    logic      end_frame;
    logic      out_load;
    res_kind_e out_kind;
  } ta_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_present;
    logic frame_end;
    logic idx_last;
    logic cur_valid;
    logic cur_free;
    logic match;
    logic out_free;
  } ta_stat_t;

endpackage

// ===== sv/iou_ta_if.sv =====
// Channel interfaces for box items and association results.
// Depends on iou_ta_pkg for field widths.
interface iou_ta_box_if import iou_ta_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  box_present;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_width;
  logic [COORD_BITS-1:0] box_height;
  logic [TIME_BITS-1:0]  frame_time;
  logic                  last_in_frame;

  modport source (output valid, box_present, box_x, box_y, box_width, box_height,
                  frame_time, last_in_frame, input ready);
  modport sink (input valid, box_present, box_x, box_y, box_width, box_height,
                frame_time, last_in_frame, output ready);
endinterface

interface iou_ta_res_if import iou_ta_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [SLOT_OUT_BITS-1:0] track_slot;
  logic                     is_new_track;
  logic                     dropped;
  logic                     capture_now;
  logic [COORD_BITS-1:0]    crop_x;
  logic [COORD_BITS-1:0]    crop_y;
  logic [SIZE_BITS-1:0]     crop_width;
  logic [SIZE_BITS-1:0]     crop_height;

  modport source (output valid, track_slot, is_new_track, dropped, capture_now,
                  crop_x, crop_y, crop_width, crop_height, input ready);
  modport sink (input valid, track_slot, is_new_track, dropped, capture_now,
                crop_x, crop_y, crop_width, crop_height, output ready);
endinterface

// ===== sv/iou_track_association_core.sv =====
// Top level of the IoU greedy track association block.
// Depends on iou_ta_pkg, iou_ta_if, iou_ta_ctrl and iou_ta_dp.
//
//   channel   dir  handshake        carries
//   box_i     in   valid/ready      one detected box, frame time, last mark
//   res_o     out  valid/ready      slot, new/dropped/capture flags, crop
//   cfg_*_i   in   write enable     capture delay, frame width, frame height
//
// Steps per box: accept, then for each old-bank slot a skip if empty or, if
// occupied, table read, edges, product and compare, stopping at a match; a
// match adds two table writes, a miss a free-slot search over up to
// TRACK_SLOTS slots; then the result is loaded. The table RAM's single write port sets this.
// Reset empties both banks at once. A stalled result holds the sequencer in
// its last step; input is taken only when the previous box is finished.
module iou_track_association_core import iou_ta_pkg::*; #(
  parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  iou_ta_box_if.sink               box_i,
  iou_ta_res_if.source             res_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);
  ta_cmd_t  cmd;
  ta_stat_t stat;

  iou_ta_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  iou_ta_dp #(.TRACK_SLOTS(TRACK_SLOTS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .box        (box_i),
    .res        (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );
endmodule

// ===== sv/iou_ta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iou_ta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ===== sv/iou_ta_ctrl.sv =====
// Sequencer for track association: slot scan, table update, free-slot
// search and result hand-off. Depends on iou_ta_pkg.
module iou_ta_ctrl import iou_ta_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ta_stat_t stat_i,
  output ta_cmd_t  cmd_o
);
  ctl_state_e state_q, state_d;
  res_kind_e  kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= RES_EMPTY;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.out_kind = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.idx_clr  = 1'b1;
        if (stat_i.in_fire) begin
          if (stat_i.in_present) begin
            state_d = ST_SCAN;
          end else begin
            kind_d  = RES_EMPTY;
            state_d = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.cur_valid) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_DIFF;
        end else if (stat_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_FREE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_DIFF: state_d = ST_MUL;
      ST_MUL:  state_d = ST_CMP;
      ST_CMP: begin
        if (stat_i.match) begin
          state_d = ST_WOLD;
        end else if (stat_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_FREE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_WOLD: begin
        cmd_o.wr_en = 1'b1;
        state_d     = ST_WNEW;
      end
      ST_WNEW: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_new    = 1'b1;
        cmd_o.set_valid = 1'b1;
        kind_d          = RES_MATCH;
        state_d         = ST_FIN;
      end
      ST_FREE: begin
        if (stat_i.cur_free) begin
          cmd_o.wr_en     = 1'b1;
          cmd_o.wr_new    = 1'b1;
          cmd_o.wr_fresh  = 1'b1;
          cmd_o.set_valid = 1'b1;
          kind_d          = RES_NEW;
          state_d         = ST_FIN;
        end else if (stat_i.idx_last) begin
          kind_d  = RES_DROP;
          state_d = ST_FIN;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.end_frame = stat_i.frame_end;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

// ===== sv/iou_ta_dp.sv =====
// Datapath: input latch, banked valid bits, track table RAM, overlap test,
// capture check with crop clipping, result register and config registers.
// Depends on iou_ta_pkg, iou_ta_if and iou_ta_ram.
module iou_ta_dp import iou_ta_pkg::*; #(
  parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  iou_ta_box_if.sink               box,
  iou_ta_res_if.source             res,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  ta_cmd_t                  cmd_i,
  output ta_stat_t                 stat_o
);
  localparam int IDX_W  = $clog2(TRACK_SLOTS);
  localparam int DEPTH  = 2 * TRACK_SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ENT_W  = $bits(entry_t);

  logic [TIME_BITS-1:0] delay_q;
  logic [SIZE_BITS-1:0] fw_q, fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= CAPTURE_DELAY_RST;
      fw_q    <= FRAME_WIDTH_RST;
      fh_q    <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_CAPTURE_DELAY: delay_q <= cfg_data_i[TIME_BITS-1:0];
        CFG_FRAME_WIDTH:   fw_q    <= cfg_data_i[SIZE_BITS-1:0];
        CFG_FRAME_HEIGHT:  fh_q    <= cfg_data_i[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input latch
  logic                  in_fire;
  logic                  present_q, last_q;
  logic [COORD_BITS-1:0] bx_q, by_q, bw_q, bh_q;
  logic [TIME_BITS-1:0]  time_q;
  logic [AREA_BITS-1:0]  area_q;

  assign box.ready = cmd_i.in_ready;
  assign in_fire   = box.valid && cmd_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      present_q <= box.box_present;
      last_q    <= box.last_in_frame;
      bx_q      <= box.box_x;
      by_q      <= box.box_y;
      bw_q      <= box.box_width;
      bh_q      <= box.box_height;
      time_q    <= box.frame_time;
      area_q    <= box.box_width * box.box_height;
    end
  end

  // slot index, bank and valid bits
  logic [IDX_W-1:0]       idx_q;
  logic                   bank_q;
  logic [TRACK_SLOTS-1:0] valid_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      bank_q     <= 1'b0;
      valid_q[0] <= '0;
      valid_q[1] <= '0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.set_valid) begin
        valid_q[~bank_q][idx_q] <= 1'b1;
      end
      if (cmd_i.end_frame) begin
        valid_q[bank_q] <= '0;
        bank_q          <= ~bank_q;
      end
    end
  end

  // track table
  entry_t              rent, wdata, upd_q;
  logic [ENT_W-1:0]    rdata_raw;
  logic [ADDR_W-1:0]   waddr, raddr;

  assign raddr = {bank_q, idx_q};
  assign waddr = {cmd_i.wr_new ? ~bank_q : bank_q, idx_q};
  assign rent  = entry_t'(rdata_raw);

  always_comb begin
    if (cmd_i.wr_fresh) begin
      wdata = '{x: bx_q, y: by_q, w: bw_q, h: bh_q, area: area_q,
                start: time_q, captured: 1'b0};
    end else begin
      wdata = upd_q;
    end
  end

  iou_ta_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  // overlap: edges, then intersection product, then 3*inter > areaA + areaB
  logic [SIZE_BITS-1:0]   a_ex, a_ey, b_ex, b_ey, lo_x, lo_y, hi_x, hi_y;
  logic [SIZE_BITS-1:0]   dx_q, dy_q;
  logic                   ok_q, ok2_q;
  logic [2*SIZE_BITS-1:0] inter_q;
  logic [2*SIZE_BITS+1:0] inter3, area_sum;

  always_comb begin
    a_ex = {1'b0, bx_q} + {1'b0, bw_q};
    a_ey = {1'b0, by_q} + {1'b0, bh_q};
    b_ex = {1'b0, rent.x} + {1'b0, rent.w};
    b_ey = {1'b0, rent.y} + {1'b0, rent.h};
    lo_x = (bx_q > rent.x) ? {1'b0, bx_q} : {1'b0, rent.x};
    lo_y = (by_q > rent.y) ? {1'b0, by_q} : {1'b0, rent.y};
    hi_x = (a_ex < b_ex) ? a_ex : b_ex;
    hi_y = (a_ey < b_ey) ? a_ey : b_ey;
  end

  always_ff @(posedge clk_i) begin
    ok_q    <= (lo_x < hi_x) && (lo_y < hi_y);
    dx_q    <= hi_x - lo_x;
    dy_q    <= hi_y - lo_y;
    ok2_q   <= ok_q;
    inter_q <= dx_q * dy_q;
  end

  assign inter3   = {1'b0, inter_q, 1'b0} + {2'b00, inter_q};
  assign area_sum = (2*SIZE_BITS+2)'(area_q) + (2*SIZE_BITS+2)'(rent.area);

  // capture check and crop clipping
  logic [TIME_BITS-1:0]  age;
  logic                  cap_d, cap_q;
  logic [COORD_BITS-1:0] cx_d, cy_d, cx_q, cy_q;
  logic [SIZE_BITS-1:0]  cw_d, ch_d, cw_q, ch_q;
  logic [SIZE_BITS-1:0]  lim_x, lim_y, px, py, rem_x, rem_y;

  always_comb begin
    age   = time_q - rent.start;
    cap_d = !rent.captured && (age >= delay_q);
    lim_x = (fw_q == '0) ? '0 : fw_q - 1'b1;
    lim_y = (fh_q == '0) ? '0 : fh_q - 1'b1;
    px    = ({1'b0, bx_q} < lim_x) ? {1'b0, bx_q} : lim_x;
    py    = ({1'b0, by_q} < lim_y) ? {1'b0, by_q} : lim_y;
    rem_x = (fw_q > px) ? fw_q - px : '0;
    rem_y = (fh_q > py) ? fh_q - py : '0;
    cx_d  = px[COORD_BITS-1:0];
    cy_d  = py[COORD_BITS-1:0];
    cw_d  = ({1'b0, bw_q} < rem_x) ? {1'b0, bw_q} : rem_x;
    ch_d  = ({1'b0, bh_q} < rem_y) ? {1'b0, bh_q} : rem_y;
  end

  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    cw_q  <= cw_d;
    ch_q  <= ch_d;
    upd_q <= '{x: bx_q, y: by_q, w: bw_q, h: bh_q, area: area_q,
               start: rent.start, captured: rent.captured | cap_d};
  end

  // result register
  logic                     out_valid_q;
  logic [SLOT_OUT_BITS-1:0] slot_q;
  logic                     new_q, drop_q, capo_q;
  logic [COORD_BITS-1:0]    ox_q, oy_q;
  logic [SIZE_BITS-1:0]     ow_q, oh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      slot_q <= '0;
      new_q  <= 1'b0;
      drop_q <= 1'b0;
      capo_q <= 1'b0;
      ox_q   <= '0;
      oy_q   <= '0;
      ow_q   <= '0;
      oh_q   <= '0;
      unique case (cmd_i.out_kind)
        RES_EMPTY: ;
        RES_MATCH: begin
          slot_q <= SLOT_OUT_BITS'(idx_q);
          if (cap_q) begin
            capo_q <= 1'b1;
            ox_q   <= cx_q;
            oy_q   <= cy_q;
            ow_q   <= cw_q;
            oh_q   <= ch_q;
          end
        end
        RES_NEW: begin
          slot_q <= SLOT_OUT_BITS'(idx_q);
          new_q  <= 1'b1;
        end
        RES_DROP: drop_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign res.valid        = out_valid_q;
  assign res.track_slot   = slot_q;
  assign res.is_new_track = new_q;
  assign res.dropped      = drop_q;
  assign res.capture_now  = capo_q;
  assign res.crop_x       = ox_q;
  assign res.crop_y       = oy_q;
  assign res.crop_width   = ow_q;
  assign res.crop_height  = oh_q;

  always_comb begin
    stat_o.in_fire    = in_fire;
    stat_o.in_present = box.box_present;
    stat_o.frame_end  = !present_q || last_q;
    stat_o.idx_last   = (idx_q == IDX_W'(TRACK_SLOTS - 1));
    stat_o.cur_valid  = valid_q[bank_q][idx_q];
    stat_o.cur_free   = !valid_q[0][idx_q] && !valid_q[1][idx_q];
    stat_o.match      = ok2_q && (inter3 > area_sum);
    stat_o.out_free   = !out_valid_q || res.ready;
  end
endmodule
